// ===== src/assert_macros.svh =====
// assertion macros shared by the tape pulse decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that holds at every clock edge out of reset
`define A_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// same-cycle implication
`define A_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define A_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define A_ALWAYS(lbl, clk, rst_n, cond)
`define A_IMPLIES(lbl, clk, rst_n, ante, cons)
`define A_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/tpbd_pkg.sv =====
// shared types, constants and width helpers for the tape pulse decoder
package tpbd_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_WIDTH = 2'd1;

    localparam logic [7:0] RST_LEAD_WIDTH = 8'd138;
    localparam logic [7:0] RST_DATA_WIDTH = 8'd61;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] MAX_PULSE_TICKS = 16'd510;
    localparam logic [7:0]  LEAD_LEARN_MIN  = 8'd150;
    localparam logic [7:0]  DATA_LEARN_LO   = 8'd45;
    localparam logic [7:0]  DATA_LEARN_HI   = 8'd150;
    localparam logic [7:0]  DATA_HALVE_AT   = 8'd90;
    localparam logic [31:0] BLOCK_HDR_BYTES = 32'd2;

    // floor(x/3) = (x*171)>>9 for x below 512
    localparam logic [16:0] DIV3_RECIP = 17'd171;

    typedef enum logic [1:0] {
        OP_PULSE   = 2'd0,
        OP_TIMEOUT = 2'd1,
        OP_START   = 2'd2,
        OP_STOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_BYTE        = 2'd0,
        KIND_BLOCK_START = 2'd1,
        KIND_BLOCK_END   = 2'd2,
        KIND_PILOT_ERR   = 2'd3
    } t_kind;

    // classified request handed from front to back
    typedef struct packed {
        t_op        op;
        logic [7:0] width;
        logic [7:0] lead;
        logic [7:0] data;
        logic [7:0] min_w;
        logic [7:0] max_w;
        logic       learn;
    } t_cmd;

    function automatic logic [7:0] two_thirds(input logic [7:0] x);
        logic [16:0] prod;
        prod = {8'd0, x, 1'b0} * DIV3_RECIP;
        return prod[16:9];
    endfunction

    function automatic logic [7:0] triple_sat(input logic [7:0] x);
        logic [9:0] t;
        t = {2'd0, x} + {1'b0, x, 1'b0};
        return (t > 10'd255) ? 8'd255 : t[7:0];
    endfunction

endpackage

// ===== src/tpbd_front.sv =====
// front end: request handshake, config registers and pulse classification
module tpbd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_opcode,
    input  logic [15:0]                    i_pulse_ticks,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output tpbd_pkg::t_cmd                 o_q_cmd
);
    import tpbd_pkg::*;

    logic [7:0] r_lead_init;
    logic [7:0] r_data_init;
    t_op        op;
    logic [7:0] w;
    logic [7:0] x;
    logic       too_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_init <= RST_LEAD_WIDTH;
            r_data_init <= RST_DATA_WIDTH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEAD_WIDTH: r_lead_init <= i_cfg_data;
                CFG_DATA_WIDTH: r_data_init <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_full;

    always_comb begin
        op       = t_op'(i_opcode);
        w        = i_pulse_ticks[8:1];
        too_long = (i_pulse_ticks > MAX_PULSE_TICKS);
        x        = (op == OP_START) ? r_data_init : w;

        o_q_cmd.op    = op;
        o_q_cmd.width = w;
        o_q_cmd.lead  = r_lead_init;
        o_q_cmd.data  = (op == OP_START) ? r_data_init
                      : ((w < DATA_HALVE_AT) ? w : {1'b0, w[7:1]});
        o_q_cmd.min_w = two_thirds(x);
        o_q_cmd.max_w = triple_sat(x);
        o_q_cmd.learn = (w >= DATA_LEARN_LO) && (w <= DATA_LEARN_HI);

        // over-long pulses are taken and dropped here
        o_q_push = i_in_valid && !i_q_full && !((op == OP_PULSE) && too_long);
    end

endmodule

// ===== src/tpbd_fifo.sv =====
// request queue between front and back
`include "assert_macros.svh"
module tpbd_fifo #(
    parameter int P_DEPTH = tpbd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tpbd_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tpbd_pkg::t_cmd o_data
);
    import tpbd_pkg::*;

    localparam int PTR_W = $clog2(P_DEPTH);
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_cmd             r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    `A_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(P_DEPTH))
    `A_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `A_IMPLIES(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

// ===== src/tpbd_back.sv =====
// back end: block state, bit packing and the result register
`include "assert_macros.svh"
module tpbd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  tpbd_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_data_byte,
    output logic [15:0]    o_block_number,
    output logic [15:0]    o_block_length,
    output logic [31:0]    o_length_offset
);
    import tpbd_pkg::*;

    typedef enum logic [4:0] {
        PH_DONE  = 5'b00001,
        PH_WAIT  = 5'b00010,
        PH_PILOT = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_ERROR = 5'b10000
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic [7:0]  r_lead_width,   n_lead_width;
    logic [7:0]  r_data_width,   n_data_width;
    logic [7:0]  r_min_width,    n_min_width;
    logic [7:0]  r_max_width,    n_max_width;
    logic [7:0]  r_shift_byte,   n_shift_byte;
    logic [2:0]  r_bit_count,    n_bit_count;
    logic [15:0] r_block_count,  n_block_count;
    logic [15:0] r_byte_count,   n_byte_count;
    logic [31:0] r_block_offset, n_block_offset;

    logic        r_out_valid;
    t_kind       r_kind;
    logic [7:0]  r_data_byte;
    logic [15:0] r_block_number;
    logic [15:0] r_block_length;
    logic [31:0] r_length_offset;

    logic        emit;
    t_kind       e_kind;
    logic [7:0]  e_byte;
    logic [15:0] e_len;
    logic [31:0] e_off;

    logic        learn_now;
    logic [7:0]  dw_e;
    logic [7:0]  min_e;
    logic [7:0]  max_e;
    logic [9:0]  dw_x3;
    logic        bit_one;
    logic        in_window;
    logic [31:0] off_sum;

    assign o_q_pop = !i_q_empty && (!r_out_valid || i_out_ready);

    always_comb begin
        learn_now = (r_data_width == 8'd0) && i_q_cmd.learn;
        dw_e      = learn_now ? i_q_cmd.data  : r_data_width;
        min_e     = learn_now ? i_q_cmd.min_w : r_min_width;
        max_e     = learn_now ? i_q_cmd.max_w : r_max_width;
        dw_x3     = {2'd0, dw_e} + {1'b0, dw_e, 1'b0};
        bit_one   = {1'b0, i_q_cmd.width} > dw_x3[9:1];
        in_window = !((i_q_cmd.width < min_e) || (i_q_cmd.width > max_e));
        off_sum   = r_block_offset + {16'd0, r_byte_count};
    end

    always_comb begin
        n_phase        = r_phase;
        n_lead_width   = r_lead_width;
        n_data_width   = r_data_width;
        n_min_width    = r_min_width;
        n_max_width    = r_max_width;
        n_shift_byte   = r_shift_byte;
        n_bit_count    = r_bit_count;
        n_block_count  = r_block_count;
        n_byte_count   = r_byte_count;
        n_block_offset = r_block_offset;
        emit           = 1'b0;
        e_kind         = KIND_BYTE;
        e_byte         = 8'd0;
        e_len          = 16'd0;
        e_off          = off_sum;

        if (o_q_pop) begin
            case (i_q_cmd.op)
                OP_START: begin
                    n_phase        = PH_WAIT;
                    n_lead_width   = i_q_cmd.lead;
                    n_data_width   = i_q_cmd.data;
                    n_min_width    = i_q_cmd.min_w;
                    n_max_width    = i_q_cmd.max_w;
                    n_shift_byte   = 8'd0;
                    n_bit_count    = 3'd0;
                    n_block_count  = 16'd0;
                    n_byte_count   = 16'd0;
                    n_block_offset = 32'd0;
                end
                OP_STOP: begin
                    n_phase = PH_DONE;
                end
                OP_TIMEOUT: begin
                    case (r_phase)
                        PH_DATA: begin
                            emit           = 1'b1;
                            e_kind         = KIND_BLOCK_END;
                            e_len          = r_byte_count;
                            e_off          = r_block_offset;
                            n_phase        = PH_WAIT;
                            n_block_offset = r_block_offset + BLOCK_HDR_BYTES;
                        end
                        PH_PILOT: begin
                            emit    = 1'b1;
                            e_kind  = KIND_PILOT_ERR;
                            n_phase = PH_ERROR;
                        end
                        default: ;
                    endcase
                end
                OP_PULSE: begin
                    case (r_phase)
                        PH_WAIT: begin
                            n_phase       = PH_PILOT;
                            n_block_count = r_block_count + 16'd1;
                            emit          = 1'b1;
                            e_kind        = KIND_BLOCK_START;
                        end
                        PH_PILOT: begin
                            if (r_lead_width == 8'd0 && i_q_cmd.width > LEAD_LEARN_MIN) begin
                                n_lead_width = i_q_cmd.width;
                            end else if (r_lead_width != 8'd0 &&
                                         i_q_cmd.width < {1'b0, r_lead_width[7:1]}) begin
                                // sync pulse
                                n_shift_byte   = 8'd0;
                                n_bit_count    = 3'd0;
                                n_phase        = PH_DATA;
                                n_block_offset = off_sum;
                                n_byte_count   = 16'd0;
                            end
                        end
                        PH_DATA: begin
                            n_data_width = dw_e;
                            n_min_width  = min_e;
                            n_max_width  = max_e;
                            if (in_window) begin
                                if (r_bit_count == 3'd7) begin
                                    n_byte_count = r_byte_count + 16'd1;
                                    n_shift_byte = 8'd0;
                                    n_bit_count  = 3'd0;
                                    emit         = 1'b1;
                                    e_kind       = KIND_BYTE;
                                    e_byte       = {r_shift_byte[7:1], bit_one};
                                    e_len        = n_byte_count;
                                    e_off        = r_block_offset;
                                end else begin
                                    n_shift_byte = {r_shift_byte[6:1], bit_one, 1'b0};
                                    n_bit_count  = r_bit_count + 3'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_DONE;
            r_lead_width   <= 8'd0;
            r_data_width   <= 8'd0;
            r_min_width    <= 8'd0;
            r_max_width    <= 8'd0;
            r_shift_byte   <= 8'd0;
            r_bit_count    <= 3'd0;
            r_block_count  <= 16'd0;
            r_byte_count   <= 16'd0;
            r_block_offset <= 32'd0;
            r_out_valid    <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_lead_width   <= n_lead_width;
            r_data_width   <= n_data_width;
            r_min_width    <= n_min_width;
            r_max_width    <= n_max_width;
            r_shift_byte   <= n_shift_byte;
            r_bit_count    <= n_bit_count;
            r_block_count  <= n_block_count;
            r_byte_count   <= n_byte_count;
            r_block_offset <= n_block_offset;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind          <= e_kind;
            r_data_byte     <= e_byte;
            r_block_number  <= n_block_count;
            r_block_length  <= e_len;
            r_length_offset <= e_off;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_data_byte     = r_data_byte;
    assign o_block_number  = r_block_number;
    assign o_block_length  = r_block_length;
    assign o_length_offset = r_length_offset;

    `A_ALWAYS(a_window_order, i_clk, i_rst_n, r_min_width <= r_max_width)
    `A_NEXT(a_byte_clears_bits, i_clk, i_rst_n, emit && e_kind == KIND_BYTE, r_bit_count == 3'd0)
    `A_NEXT(a_start_enters_pilot, i_clk, i_rst_n, emit && e_kind == KIND_BLOCK_START, r_phase == PH_PILOT)

endmodule

// ===== src/tape_pulse_block_decoder.sv =====
// top level of the tape pulse block decoder
//
//  channel  direction  handshake                   payload
//  in       request    i_in_valid / o_in_ready     i_opcode, i_pulse_ticks
//  out      result     o_out_valid / i_out_ready   o_kind, o_data_byte, o_block_number,
//                                                  o_block_length, o_length_offset
//  cfg      write      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  one request per cycle while the queue is not full; a request that yields a result
//  is written to the queue, then popped into the result register in the back end
//  the queue of P_QUEUE_DEPTH entries lets the front keep taking requests while
//  the result register is stalled; o_in_ready drops only when the queue is full
//  synchronous active-low reset; config writes are always ready
module tape_pulse_block_decoder #(
    parameter int P_QUEUE_DEPTH = tpbd_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_opcode,
    input  logic [15:0]                    i_pulse_ticks,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_kind,
    output logic [7:0]                     o_data_byte,
    output logic [15:0]                    o_block_number,
    output logic [15:0]                    o_block_length,
    output logic [31:0]                    o_length_offset,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import tpbd_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_cmd q_in;
    t_cmd q_out;

    tpbd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_pulse_ticks (i_pulse_ticks),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_in)
    );

    tpbd_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    tpbd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_cmd         (q_out),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_block_number  (o_block_number),
        .o_block_length  (o_block_length),
        .o_length_offset (o_length_offset)
    );

endmodule
